// ===== rtl/kast_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kast_pkg: shared types, constants and helpers of the source tokenizer
// Token and bundle types, kind codes, character constants and the keyword
// and punctuator tables.
// ----------------------------------------------------------------------------
package kast_pkg;

    localparam int OFFSET_BITS       = 16;
    localparam int KEYWORD_MAX_CHARS = 6;
    localparam int CAP_BITS          = KEYWORD_MAX_CHARS * 8;
    localparam int LEN_BITS          = 16;
    localparam int KIND_BITS         = 5;
    localparam int SLOTS             = 3;
    localparam int COUNT_BITS        = 2;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QUEUE_PTR_BITS    = 2;
    localparam int QUEUE_CNT_BITS    = 3;
    localparam int KEYWORDS          = 7;
    localparam int PUNCTS            = 15;

    localparam logic [KIND_BITS-1:0] KIND_IDENT    = 5'd0;
    localparam logic [KIND_BITS-1:0] KIND_NUMBER   = 5'd1;
    localparam logic [KIND_BITS-1:0] KIND_KEYWORD0 = 5'd2;
    localparam logic [KIND_BITS-1:0] KIND_PUNCT0   = 5'd9;
    localparam logic [KIND_BITS-1:0] KIND_LBRACE   = 5'd17;
    localparam logic [KIND_BITS-1:0] KIND_SEMI     = 5'd21;
    localparam logic [KIND_BITS-1:0] KIND_END      = 5'd24;

    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUMBER
    } scan_mode_t;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [15:0]          start;
        logic [LEN_BITS-1:0]  length;
    } token_t;

    // All tokens caused by one input item, oldest in slot 0.
    typedef struct packed {
        token_t [SLOTS-1:0]    tok;
        logic [COUNT_BITS-1:0] count;
        logic                  overflow;
    } bundle_t;

    // Keywords packed with the last character in the low byte.
    localparam logic [63:0] KW_PACKED [KEYWORDS] = '{
        64'h0000_0000_656C_7365,   // else
        64'h0000_0000_6675_6E63,   // func
        64'h0000_0000_0066_6F72,   // for
        64'h0000_0000_0000_6966,   // if
        64'h0000_7265_7475_726E,   // return
        64'h0000_0000_006C_6574,   // let
        64'h0000_0077_6869_6C65    // while
    };
    localparam logic [LEN_BITS-1:0] KW_LEN [KEYWORDS] = '{
        16'd4, 16'd4, 16'd3, 16'd2, 16'd6, 16'd3, 16'd5
    };

    // Punctuators in kind order: + - * / % = ( ) { } [ ] ; , :
    localparam logic [7:0] PUNCT_CHAR [PUNCTS] = '{
        8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h3D, 8'h28, 8'h29,
        8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h3B, 8'h2C, 8'h3A
    };

    function automatic logic [KIND_BITS-1:0] word_kind(
        input logic [CAP_BITS-1:0] cap,
        input logic [LEN_BITS-1:0] len
    );
        logic [KIND_BITS-1:0] kind;
        kind = KIND_IDENT;
        for (int k = 0; k < KEYWORDS; k++)
        begin
            if (len == KW_LEN[k] && 64'(cap) == KW_PACKED[k])
            begin
                kind = KIND_KEYWORD0 + KIND_BITS'(k);
            end
        end
        return kind;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [15:0] pos_to_offset(input logic [OFFSET_BITS-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return w[15:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/kast_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kast_front: byte classifier and scanner state
// Accepts one byte per cycle while the queue is not full, updates the run
// state and builds the bundle of tokens that the byte causes.
// ----------------------------------------------------------------------------
module kast_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic              queue_full,
    input  wire logic [7:0]        char_byte,
    input  wire logic              byte_valid,
    input  wire logic              end_of_text,
    output kast_pkg::bundle_t      bundle,
    output logic                   bundle_push
);

    kast_pkg::scan_mode_t                      mode_reg, mode_next;
    logic [15:0]                               run_start_reg, run_start_next;
    logic [kast_pkg::LEN_BITS-1:0]             run_length_reg, run_length_next;
    logic [kast_pkg::CAP_BITS-1:0]             capture_reg, capture_next;
    logic [kast_pkg::OFFSET_BITS-1:0]          position_reg, position_next;
    logic [kast_pkg::KIND_BITS-1:0]            prev_kind_reg, prev_kind_next;
    logic                                      any_emitted_reg, any_emitted_next;
    logic                                      saturated_reg, saturated_next;

    logic                                      take;

    assign take = push && !queue_full;

    always_comb
    begin
        logic                           letter;
        logic                           digit;
        logic                           extend;
        logic                           found;
        logic [kast_pkg::KIND_BITS-1:0] punct_kind;
        logic [kast_pkg::KIND_BITS-1:0] prev;
        logic                           any;
        logic [kast_pkg::COUNT_BITS-1:0] n;
        kast_pkg::token_t               tok;

        letter     = kast_pkg::is_letter(char_byte);
        digit      = kast_pkg::is_numeral(char_byte);
        extend     = 1'b0;
        found      = 1'b0;
        punct_kind = kast_pkg::KIND_PUNCT0;
        for (int k = 0; k < kast_pkg::PUNCTS; k++)
        begin
            if (char_byte == kast_pkg::PUNCT_CHAR[k])
            begin
                found      = 1'b1;
                punct_kind = kast_pkg::KIND_PUNCT0 + kast_pkg::KIND_BITS'(k);
            end
        end

        mode_next        = mode_reg;
        run_start_next   = run_start_reg;
        run_length_next  = run_length_reg;
        capture_next     = capture_reg;
        position_next    = position_reg;
        saturated_next   = saturated_reg;
        prev             = prev_kind_reg;
        any              = any_emitted_reg;
        n                = '0;
        bundle           = '0;
        tok              = '0;

        if (byte_valid)
        begin
            extend = (mode_reg == kast_pkg::MODE_WORD && (letter || digit)) ||
                     (mode_reg == kast_pkg::MODE_NUMBER && digit);
            if (extend)
            begin
                if (run_length_reg < kast_pkg::LEN_BITS'(kast_pkg::KEYWORD_MAX_CHARS))
                begin
                    capture_next = {capture_reg[kast_pkg::CAP_BITS-9:0], char_byte};
                end
                if (run_length_reg != kast_pkg::LEN_MAX)
                begin
                    run_length_next = run_length_reg + 1'b1;
                end
            end
            else
            begin
                // A byte that does not continue the run closes it first.
                if (mode_reg != kast_pkg::MODE_IDLE)
                begin
                    tok.kind   = (mode_reg == kast_pkg::MODE_WORD) ?
                                 kast_pkg::word_kind(capture_reg, run_length_reg) :
                                 kast_pkg::KIND_NUMBER;
                    tok.start  = run_start_reg;
                    tok.length = run_length_reg;
                    bundle.tok[n] = tok;
                    n    = n + 1'b1;
                    prev = tok.kind;
                    any  = 1'b1;
                end
                mode_next = kast_pkg::MODE_IDLE;
                if (letter || digit)
                begin
                    mode_next       = letter ? kast_pkg::MODE_WORD : kast_pkg::MODE_NUMBER;
                    run_start_next  = kast_pkg::pos_to_offset(position_reg);
                    run_length_next = kast_pkg::LEN_BITS'(1);
                    capture_next    = kast_pkg::CAP_BITS'(char_byte);
                end
                else if (char_byte == kast_pkg::CHAR_LF)
                begin
                    if (any && prev != kast_pkg::KIND_SEMI && prev != kast_pkg::KIND_LBRACE)
                    begin
                        tok.kind   = kast_pkg::KIND_SEMI;
                        tok.start  = kast_pkg::pos_to_offset(position_reg);
                        tok.length = '0;
                        bundle.tok[n] = tok;
                        n    = n + 1'b1;
                        prev = tok.kind;
                        any  = 1'b1;
                    end
                end
                else if (found)
                begin
                    tok.kind   = punct_kind;
                    tok.start  = kast_pkg::pos_to_offset(position_reg);
                    tok.length = kast_pkg::LEN_BITS'(1);
                    bundle.tok[n] = tok;
                    n    = n + 1'b1;
                    prev = tok.kind;
                    any  = 1'b1;
                end
            end
            if (position_reg == '1)
            begin
                saturated_next = 1'b1;
            end
            else
            begin
                position_next = position_reg + 1'b1;
            end
        end

        bundle.overflow = saturated_next;

        if (end_of_text)
        begin
            if (mode_next != kast_pkg::MODE_IDLE)
            begin
                tok.kind   = (mode_next == kast_pkg::MODE_WORD) ?
                             kast_pkg::word_kind(capture_next, run_length_next) :
                             kast_pkg::KIND_NUMBER;
                tok.start  = run_start_next;
                tok.length = run_length_next;
                bundle.tok[n] = tok;
                n = n + 1'b1;
            end
            tok.kind   = kast_pkg::KIND_END;
            tok.start  = kast_pkg::pos_to_offset(position_next);
            tok.length = '0;
            bundle.tok[n] = tok;
            n = n + 1'b1;
            // Start over for the next text.
            mode_next       = kast_pkg::MODE_IDLE;
            run_start_next  = '0;
            run_length_next = '0;
            capture_next    = '0;
            position_next   = '0;
            saturated_next  = 1'b0;
            prev            = '0;
            any             = 1'b0;
        end

        prev_kind_next   = prev;
        any_emitted_next = any;
        bundle.count     = n;
        bundle_push      = take && (n != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= kast_pkg::MODE_IDLE;
            run_start_reg   <= '0;
            run_length_reg  <= '0;
            capture_reg     <= '0;
            position_reg    <= '0;
            prev_kind_reg   <= '0;
            any_emitted_reg <= 1'b0;
            saturated_reg   <= 1'b0;
        end
        else if (take)
        begin
            mode_reg        <= mode_next;
            run_start_reg   <= run_start_next;
            run_length_reg  <= run_length_next;
            capture_reg     <= capture_next;
            position_reg    <= position_next;
            prev_kind_reg   <= prev_kind_next;
            any_emitted_reg <= any_emitted_next;
            saturated_reg   <= saturated_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/kast_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kast_queue: bundle queue between front and back
// A small register queue that decouples the scanner from the token drain.
// ----------------------------------------------------------------------------
module kast_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire kast_pkg::bundle_t wr_data,
    input  wire logic              rd_en,
    output kast_pkg::bundle_t      rd_data,
    output logic                   full,
    output logic                   empty
);

    kast_pkg::bundle_t                      store_reg [kast_pkg::QUEUE_DEPTH];
    logic [kast_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [kast_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [kast_pkg::QUEUE_CNT_BITS-1:0]    count_reg, count_next;
    logic                                   do_wr;
    logic                                   do_rd;

    assign full    = count_reg == kast_pkg::QUEUE_CNT_BITS'(kast_pkg::QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/kast_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kast_back: token drain
// Walks the tokens of the head bundle one transaction at a time and releases
// the bundle after its final token.
// ----------------------------------------------------------------------------
module kast_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire kast_pkg::bundle_t             head,
    input  wire logic                          head_valid,
    input  wire logic                          pop,
    output logic                               head_pop,
    output logic [kast_pkg::KIND_BITS-1:0]     token_kind,
    output logic [15:0]                        start_offset,
    output logic [kast_pkg::LEN_BITS-1:0]      token_length,
    output logic                               offset_overflow,
    output logic                               last_of_run
);

    logic [kast_pkg::COUNT_BITS-1:0] slot_reg, slot_next;
    kast_pkg::token_t                cur;
    logic                            take;

    assign cur             = head.tok[slot_reg];
    assign token_kind      = cur.kind;
    assign start_offset    = cur.start;
    assign token_length    = cur.length;
    assign offset_overflow = head.overflow;
    assign last_of_run     = slot_reg == head.count - 1'b1;
    assign take            = pop && head_valid;
    assign head_pop        = take && last_of_run;

    always_comb
    begin
        slot_next = slot_reg;
        if (take)
        begin
            slot_next = last_of_run ? '0 : slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/keyword_aware_source_tokenizer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyword_aware_source_tokenizer_top: streaming source tokenizer
// Turns a byte stream into identifier, number, keyword, punctuator, inserted
// semicolon and end tokens, each given as kind, start offset and length.
// ----------------------------------------------------------------------------
//
// Channel   Handshake          Payload
// --------  -----------------  ----------------------------------------------
// input     push / full        char_byte, byte_valid, end_of_text
// result    pop / empty        token_kind, start_offset, token_length,
//                              offset_overflow, last_of_run
//
// The front scanner takes one input transaction per cycle whenever the
// four-entry bundle queue has room, so bytes stream at one per clock.
// Each byte yields zero to three tokens, which are drained one result
// transaction per cycle while pop is held; a byte that causes no token never
// occupies the queue. A stalled result side fills the queue and then raises
// full. Reset returns the scanner to the start of a new text and empties the
// queue; no clearing pass is needed.
//
module keyword_aware_source_tokenizer_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [7:0]    char_byte,
    input  wire logic          byte_valid,
    input  wire logic          end_of_text,
    output logic               empty,
    input  wire logic          pop,
    output logic [4:0]         token_kind,
    output logic [15:0]        start_offset,
    output logic [15:0]        token_length,
    output logic               offset_overflow,
    output logic               last_of_run
);

    // Bundle of tokens from the front, and the oldest one awaiting drain.
    kast_pkg::bundle_t front_bundle;
    kast_pkg::bundle_t head_bundle;
    logic              bundle_push;
    logic              head_pop;
    logic              queue_full;
    logic              queue_empty;

    // The scanner only commits its state when the queue can take whatever
    // the byte produces, so full simply mirrors the queue.
    assign full  = queue_full;
    assign empty = queue_empty;

    kast_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .queue_full  (queue_full),
        .char_byte   (char_byte),
        .byte_valid  (byte_valid),
        .end_of_text (end_of_text),
        .bundle      (front_bundle),
        .bundle_push (bundle_push)
    );

    kast_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (bundle_push),
        .wr_data (front_bundle),
        .rd_en   (head_pop),
        .rd_data (head_bundle),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    // The back end walks the head bundle slot by slot; last_of_run marks the
    // final token that one input byte caused.
    kast_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head_bundle),
        .head_valid      (!queue_empty),
        .pop             (pop),
        .head_pop        (head_pop),
        .token_kind      (token_kind),
        .start_offset    (start_offset),
        .token_length    (token_length),
        .offset_overflow (offset_overflow),
        .last_of_run     (last_of_run)
    );

endmodule
`default_nettype wire
